[hdl/ostt_pkg.sv]
// shared types, codes and constants of the one-shot timer table
`timescale 1ns / 1ps
`default_nettype none

package ostt_pkg;

   localparam int TimerSlotsDefault = 16;
   localparam logic [31:0] SleepCapReset = 32'd1000000;
   localparam logic [9:0] UsPerMs = 10'd1000;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] KIND_ACK    = 2'd0;
   localparam logic [1:0] KIND_EXPIRY = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_BAD_TIMEOUT = 2'd1;
   localparam logic [1:0] STATUS_FULL        = 2'd2;

   localparam logic REG_SLEEP_CAP = 1'b0;

   typedef struct packed {
      logic               op;
      logic [47:0]        now_us;
      logic signed [31:0] timeout_ms;
      logic [15:0]        owner;
      logic [31:0]        tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [15:0] expired_owner;
      logic [31:0] expired_tag;
      logic [31:0] next_sleep_us;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [41:0] remaining;
      logic [47:0] stamp;
      logic [15:0] owner;
      logic [31:0] tag;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_FIND,
      ST_ADD_ACK,
      ST_TICK_SCAN,
      ST_TICK_END
   } state_type;

endpackage

`default_nettype wire

[hdl/one_shot_timer_table_unit.sv]
// one-shot timer table: entry memory, free-slot search and tick scan
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_data  (req_type)
//   rsp      out        rsp_valid/rsp_stall   rsp_data  (rsp_type)
//   csr      in/out     psel/penable/pready   paddr, pwdata, prdata
//
// one item at a time. an add gives its acknowledge after the free-slot search that
// checks one slot a cycle. a tick is paced by the single read port of the entry
// memory that visits one slot a cycle, except while rsp_stall holds an expiry.
// reset clears the valid and pending flip-flops at once, no clearing pass.
// a stalled expiry freezes the scan in place until the output register drains.
`timescale 1ns / 1ps
`default_nettype none

module one_shot_timer_table_unit import ostt_pkg::*; #(
   parameter int TIMER_SLOTS = TimerSlotsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      rsp_type     rsp_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);

   localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CW = $clog2(TIMER_SLOTS + 1);

   state_type state_ff, state_in;

   logic [31:0] cap_ff, cap_in;
   logic [TIMER_SLOTS-1:0] valid_ff, valid_in;
   logic [TIMER_SLOTS-1:0] pending_ff, pending_in;

   req_type req_ff, req_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [1:0] status_ff, status_in;
   logic eval_valid_ff, eval_valid_in;
   logic [IW-1:0] eval_idx_ff, eval_idx_in;
   logic cmp_valid_ff, cmp_valid_in;
   logic [41:0] cmp_rem_ff, cmp_rem_in;
   logic [31:0] min_ff, min_in;

   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_load;
   logic emit;

   // entry memory
   entry_type mem [TIMER_SLOTS];
   entry_type mem_q_ff;
   logic mem_we;
   logic [IW-1:0] mem_wa;
   entry_type mem_wd;
   logic [IW-1:0] rd_addr;

   logic in_take, out_free, cfg_write, add_positive, rd_more, find_last;
   logic [48:0] since;
   logic [47:0] elapsed;
   logic [48:0] left;
   logic [41:0] rem_new;
   logic ev_live, ev_pend, ev_active, ev_expire, ev_hold, ev_fire;

   assign req_stall = (state_ff != ST_IDLE);
   assign in_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assign pready = 1'b1;
   assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SLEEP_CAP);
   assign prdata = (paddr[2] == REG_SLEEP_CAP) ? cap_ff : 32'd0;
   assign cap_in = cfg_write ? pwdata : cap_ff;

   assign add_positive = !req_data.timeout_ms[31] && (req_data.timeout_ms != 32'sd0);
   assign rem_new = 42'(req_ff.timeout_ms[30:0]) * 42'(UsPerMs);
   assign find_last = (idx_ff == CW'(TIMER_SLOTS - 1));
   assign rd_more = (idx_ff != CW'(TIMER_SLOTS));

   // evaluation of the entry read last cycle
   assign ev_live = valid_ff[eval_idx_ff];
   assign ev_pend = pending_ff[eval_idx_ff];
   assign since = {1'b0, req_ff.now_us} - {1'b0, mem_q_ff.stamp};
   assign elapsed = since[48] ? 48'd0 : since[47:0];
   assign left = {7'd0, mem_q_ff.remaining} - {1'b0, elapsed};
   assign ev_active = (state_ff == ST_TICK_SCAN) && eval_valid_ff && ev_live && !ev_pend;
   assign ev_expire = ev_active && (left[48] || (left == 49'd0));
   assign ev_hold = ev_expire && !out_free;
   assign ev_fire = (state_ff == ST_TICK_SCAN) && eval_valid_ff && !ev_hold;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_take) begin
               if (req_data.op == OP_TICK) begin
                  state_in = ST_TICK_SCAN;
               end else if (add_positive) begin
                  state_in = ST_ADD_FIND;
               end else begin
                  state_in = ST_ADD_ACK;
               end
            end
         end
         ST_ADD_FIND: begin
            if (!valid_ff[idx_ff[IW-1:0]] || find_last) begin
               state_in = ST_ADD_ACK;
            end
         end
         ST_ADD_ACK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_TICK_SCAN: begin
            if (!rd_more && !eval_valid_ff) begin
               state_in = ST_TICK_END;
            end
         end
         ST_TICK_END: begin
            if (!cmp_valid_ff && out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result selection
   always_comb begin
      emit = 1'b0;
      rsp_load = '0;
      case (state_ff)
         ST_ADD_ACK: begin
            emit = out_free;
            rsp_load.kind = KIND_ACK;
            rsp_load.status = status_ff;
            rsp_load.last = 1'b1;
         end
         ST_TICK_SCAN: begin
            emit = ev_fire && ev_expire;
            rsp_load.kind = KIND_EXPIRY;
            rsp_load.status = STATUS_OK;
            rsp_load.expired_owner = mem_q_ff.owner;
            rsp_load.expired_tag = mem_q_ff.tag;
         end
         ST_TICK_END: begin
            emit = !cmp_valid_ff && out_free;
            rsp_load.kind = KIND_END;
            rsp_load.status = STATUS_OK;
            rsp_load.next_sleep_us = min_ff;
            rsp_load.last = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   // datapath and table control
   always_comb begin
      req_in = req_ff;
      idx_in = idx_ff;
      status_in = status_ff;
      valid_in = valid_ff;
      pending_in = pending_ff;
      eval_valid_in = eval_valid_ff;
      eval_idx_in = eval_idx_ff;
      cmp_valid_in = 1'b0;
      cmp_rem_in = cmp_rem_ff;
      min_in = min_ff;
      mem_we = 1'b0;
      mem_wa = idx_ff[IW-1:0];
      mem_wd = mem_q_ff;
      rd_addr = idx_ff[IW-1:0];

      // running minimum, one stage behind the evaluation
      if (cmp_valid_ff && (cmp_rem_ff < {10'd0, min_ff})) begin
         min_in = cmp_rem_ff[31:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (in_take) begin
               req_in = req_data;
               idx_in = '0;
               eval_valid_in = 1'b0;
               min_in = cap_ff;
               status_in = add_positive ? STATUS_OK : STATUS_BAD_TIMEOUT;
            end
         end
         ST_ADD_FIND: begin
            if (!valid_ff[idx_ff[IW-1:0]]) begin
               mem_we = 1'b1;
               mem_wd.remaining = rem_new;
               mem_wd.stamp = req_ff.now_us;
               mem_wd.owner = req_ff.owner;
               mem_wd.tag = req_ff.tag;
               valid_in[idx_ff[IW-1:0]] = 1'b1;
               pending_in[idx_ff[IW-1:0]] = 1'b1;
               status_in = STATUS_OK;
            end else if (find_last) begin
               status_in = STATUS_FULL;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_TICK_SCAN: begin
            // a held expiry rereads its own slot so the read data stays put
            if (ev_hold) begin
               rd_addr = eval_idx_ff;
            end else begin
               eval_valid_in = rd_more;
               eval_idx_in = idx_ff[IW-1:0];
               idx_in = idx_ff + CW'(rd_more);
            end
            if (ev_fire && ev_live) begin
               if (ev_expire) begin
                  valid_in[eval_idx_ff] = 1'b0;
               end else if (ev_active) begin
                  mem_we = 1'b1;
                  mem_wa = eval_idx_ff;
                  mem_wd.remaining = left[41:0];
                  mem_wd.stamp = req_ff.now_us;
                  cmp_valid_in = 1'b1;
                  cmp_rem_in = left[41:0];
               end else begin
                  pending_in[eval_idx_ff] = 1'b0;
                  cmp_valid_in = 1'b1;
                  cmp_rem_in = mem_q_ff.remaining;
               end
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff <= SleepCapReset;
         valid_ff <= '0;
         pending_ff <= '0;
         eval_valid_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cap_ff <= cap_in;
         valid_ff <= valid_in;
         pending_ff <= pending_in;
         eval_valid_ff <= eval_valid_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      idx_ff <= idx_in;
      status_ff <= status_in;
      eval_idx_ff <= eval_idx_in;
      cmp_rem_ff <= cmp_rem_in;
      min_ff <= min_in;
      if (emit) begin
         rsp_data_ff <= rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[tb/sv/one_shot_timer_table_unit_test.sv]
// self-checking testbench of the one-shot timer table: directed table, random traffic, csr phases
`timescale 1ns / 1ps

module one_shot_timer_table_unit_test;
   import ostt_pkg::*;

   localparam int TableSlots = TimerSlotsDefault;
   localparam logic [2:0] CapAddr = 3'({REG_SLEEP_CAP, 2'b00});

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   one_shot_timer_table_unit #(.TIMER_SLOTS(TableSlots)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the timer table
   logic        tbl_valid [TableSlots];
   logic        tbl_pending [TableSlots];
   logic [41:0] tbl_remaining [TableSlots];
   logic [47:0] tbl_stamp [TableSlots];
   logic [15:0] tbl_owner [TableSlots];
   logic [31:0] tbl_tag [TableSlots];
   logic [31:0] cap_us = SleepCapReset;

   rsp_type step_rsps[$];
   rsp_type awaited_rsps[$];
   int      mismatch_count = 0;
   int      rsp_count = 0;
   logic    quiet_mode = 1'b0;
   logic [47:0] clock_now_us = '0;
   int      burst_left = 0;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   stim_row_type directed_rows[$];

   initial begin
      for (int i = 0; i < TableSlots; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_pending[i] = 1'b0;
      end
   end

   // expected results of one item, and the table update it causes
   task automatic predict_step(input req_type it);
      int          slot;
      logic [47:0] elapsed;
      logic [41:0] least;
      rsp_type     r;
      step_rsps.delete();
      if (it.op == OP_ADD) begin
         r = '0;
         r.kind = KIND_ACK;
         r.last = 1'b1;
         slot = -1;
         if ($signed(it.timeout_ms) <= 0) begin
            r.status = STATUS_BAD_TIMEOUT;
         end else begin
            for (int i = 0; i < TableSlots; i++)
               if (!tbl_valid[i] && slot < 0) slot = i;
            if (slot < 0) begin
               r.status = STATUS_FULL;
            end else begin
               r.status = STATUS_OK;
               tbl_valid[slot] = 1'b1;
               tbl_pending[slot] = 1'b1;
               tbl_remaining[slot] = {10'd0, $unsigned(it.timeout_ms)} * 42'(UsPerMs);
               tbl_stamp[slot] = it.now_us;
               tbl_owner[slot] = it.owner;
               tbl_tag[slot] = it.tag;
            end
         end
         step_rsps.push_back(r);
      end else begin
         for (int i = 0; i < TableSlots; i++) begin
            if (tbl_valid[i] && !tbl_pending[i]) begin
               elapsed = (it.now_us >= tbl_stamp[i]) ? it.now_us - tbl_stamp[i] : '0;
               if (elapsed >= {6'd0, tbl_remaining[i]}) begin
                  r = '0;
                  r.kind = KIND_EXPIRY;
                  r.expired_owner = tbl_owner[i];
                  r.expired_tag = tbl_tag[i];
                  step_rsps.push_back(r);
                  tbl_valid[i] = 1'b0;
               end else begin
                  tbl_remaining[i] = tbl_remaining[i] - elapsed[41:0];
                  tbl_stamp[i] = it.now_us;
               end
            end
         end
         // promoted entries count toward the minimum too
         least = {10'd0, cap_us};
         for (int i = 0; i < TableSlots; i++) begin
            if (tbl_valid[i]) begin
               tbl_pending[i] = 1'b0;
               if (tbl_remaining[i] < least) least = tbl_remaining[i];
            end
         end
         r = '0;
         r.kind = KIND_END;
         r.next_sleep_us = least[31:0];
         r.last = 1'b1;
         step_rsps.push_back(r);
      end
   endtask

   task automatic cmp_field(input string name, input logic [63:0] exp_v,
                            input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count <= rsp_count + 1;
         if (awaited_rsps.size() == 0) begin
            $display("%0t: result with none expected, got %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = awaited_rsps.pop_front();
            cmp_field("kind", 64'(want.kind), 64'(rsp_data.kind));
            cmp_field("status", 64'(want.status), 64'(rsp_data.status));
            cmp_field("expired_owner", 64'(want.expired_owner),
                      64'(rsp_data.expired_owner));
            cmp_field("expired_tag", 64'(want.expired_tag), 64'(rsp_data.expired_tag));
            cmp_field("next_sleep_us", 64'(want.next_sleep_us),
                      64'(rsp_data.next_sleep_us));
            cmp_field("last", 64'(want.last), 64'(rsp_data.last));
         end
      end
   end

   // result side back-pressure, with one long hold once traffic is flowing
   int   hold_left = 0;
   bit   hold_done = 1'b0;
   int   run_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && rsp_count >= 250) begin
         hold_done <= 1'b1;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else if (run_left != 0) begin
         run_left <= run_left - 1;
      end else begin
         rsp_stall <= !quiet_mode && ($urandom_range(0, 3) == 0);
         run_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(0, 3);
      end
   end

   function automatic int idle_gap();
      int pick;
      if (quiet_mode) return 0;
      pick = $urandom_range(0, 19);
      if (pick < 10) return 0;
      if (pick < 17) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic transfer_item(input req_type it, input bit typed, input rsp_type want);
      int gap;
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_step(it);
      if (typed) begin
         awaited_rsps.push_back(want);
      end else begin
         foreach (step_rsps[k]) awaited_rsps.push_back(step_rsps[k]);
      end
      gap = idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (TableSlots + 4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == CapAddr) cap_us = value;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [2:0] addr, input logic [31:0] want);
      logic [31:0] got;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      got = prdata;
      cmp_field("sleep_cap_us", 64'(want), 64'(got));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type add_req(input logic [47:0] now, input logic [31:0] tout,
                                       input logic [15:0] own, input logic [31:0] tg);
      req_type it;
      it = '0;
      it.op = OP_ADD;
      it.now_us = now;
      it.timeout_ms = tout;
      it.owner = own;
      it.tag = tg;
      return it;
   endfunction

   function automatic req_type tick_req(input logic [47:0] now);
      req_type it;
      it = '0;
      it.op = OP_TICK;
      it.now_us = now;
      return it;
   endfunction

   function automatic rsp_type ack_rsp(input logic [1:0] st);
      rsp_type r;
      r = '0;
      r.kind = KIND_ACK;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic rsp_type end_rsp(input logic [31:0] sleep);
      rsp_type r;
      r = '0;
      r.kind = KIND_END;
      r.next_sleep_us = sleep;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic push_row(input req_type it, input bit typed, input rsp_type want);
      stim_row_type row;
      row.item = it;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   // well-formed traffic on a mostly forward running clock, with bursts that fill the table
   function automatic req_type random_item();
      req_type it;
      int      pick;
      it = '0;
      it.owner = 16'($urandom);
      it.tag = $urandom;
      if (burst_left == 0 && $urandom_range(0, 39) == 0) burst_left = $urandom_range(10, 20);
      if (burst_left != 0 || $urandom_range(0, 1) == 0) begin
         if (burst_left != 0) burst_left--;
         it.op = OP_ADD;
         pick = $urandom_range(0, 99);
         if (pick < 80) it.timeout_ms = $urandom_range(1, 40);
         else if (pick < 85) it.timeout_ms = $urandom_range(41, 3000);
         else if (pick < 92) it.timeout_ms = $urandom & 32'h7FFF_FFFF;
         else if (pick < 95) it.timeout_ms = '0;
         else it.timeout_ms = $urandom | 32'h8000_0000;
      end else begin
         it.op = OP_TICK;
         it.timeout_ms = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 85) clock_now_us = clock_now_us + 48'($urandom_range(0, 15000));
         else if (pick < 90) clock_now_us = clock_now_us + 48'($urandom_range(15000, 60000));
         else if (pick < 97) clock_now_us = clock_now_us - 48'($urandom_range(0, 20000));
         else clock_now_us = {16'($urandom), $urandom};
      end
      it.now_us = clock_now_us;
      return it;
   endfunction

   initial begin : stimulus
      logic [31:0] caps [5];
      rsp_type     none;
      none = '0;
      caps[0] = 32'd5000;
      caps[1] = 32'd0;
      caps[2] = 32'hFFFF_FFFF;
      caps[3] = 32'd1;
      caps[4] = $urandom_range(1000, 100000);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(CapAddr, SleepCapReset);

      // empty table, rejected timeouts, largest timeout, fill up, full, then tick through
      push_row(tick_req(48'd0), 1'b1, end_rsp(SleepCapReset));
      push_row(add_req(48'd0, 32'd0, 16'h1234, 32'h5678), 1'b1, ack_rsp(STATUS_BAD_TIMEOUT));
      push_row(add_req(48'd0, 32'hFFFF_FFFF, 16'h1, 32'h2), 1'b1, ack_rsp(STATUS_BAD_TIMEOUT));
      push_row(add_req(48'd0, 32'h8000_0000, 16'h3, 32'h4), 1'b1, ack_rsp(STATUS_BAD_TIMEOUT));
      push_row(add_req(48'd0, 32'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
               ack_rsp(STATUS_OK));
      for (int i = 1; i < TableSlots; i++)
         push_row(add_req(48'd1000, i, 16'(i - 1), (i == 1) ? 32'd0 : $urandom), 1'b0, none);
      push_row(add_req(48'd1000, 32'd5, 16'h77, 32'h88), 1'b1, ack_rsp(STATUS_FULL));
      push_row(tick_req(48'd2000), 1'b0, none);
      push_row(tick_req(48'd9000), 1'b0, none);
      push_row(tick_req(48'd500), 1'b0, none);
      push_row(tick_req(48'hFFFF_FFFF_FFFF), 1'b0, none);
      push_row(tick_req(48'hFFFF_FFFF_FFFF), 1'b1, end_rsp(SleepCapReset));
      foreach (directed_rows[k])
         transfer_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
      drain_results();

      for (int ph = 0; ph < 5; ph++) begin
         csr_write(CapAddr, caps[ph]);
         csr_check(CapAddr, caps[ph]);
         quiet_mode <= (ph == 2);
         for (int n = 0; n < 90; n++) begin
            // sender waits here until the block has nothing left in flight
            if (n == 45) drain_results();
            transfer_item(random_item(), 1'b0, none);
         end
         drain_results();
      end

      if (mismatch_count == 0) begin
         $display("one_shot_timer_table_unit_test: PASS");
      end else begin
         $display("one_shot_timer_table_unit_test: FAIL");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("one_shot_timer_table_unit_test: FAIL");
      $finish;
   end

endmodule
